### design/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants of the heightmap triangle sampler
// Grid geometry, fixed-point format, command codes, register map, and the
// structs that pass between the front, the queue and the back.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

  // Grid and number format
  localparam int MAX_WIDTH   = 512;
  localparam int MAX_DEPTH   = 512;
  localparam int FRAC_BITS   = 16;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_DEPTH);
  localparam int BANK_AW     = (COL_W - 1) + (ROW_W - 1);
  localparam int BANK_DEPTH  = 1 << BANK_AW;
  localparam int NUM_BANKS   = 4;
  localparam int ONE_FX      = 1 << FRAC_BITS;

  // Field widths
  localparam int DIM_W       = 10;
  localparam int VAL_W       = 24;
  localparam int COORD_W     = 32;
  localparam int SAMPLE_W    = 8;
  localparam int OUT_W       = 41;
  localparam int PROD_W      = COORD_W + VAL_W + 1;
  localparam int POS_W       = PROD_W - 1 - 2 * FRAC_BITS;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // APB
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_HEIGHT = 2'd1,
    OP_NORMAL = 2'd2
  } op_t;

  localparam logic [2:0] REG_GRID_WIDTH = 3'd0;
  localparam logic [2:0] REG_GRID_DEPTH = 3'd1;
  localparam logic [2:0] REG_CELL_X     = 3'd2;
  localparam logic [2:0] REG_CELL_Z     = 3'd3;
  localparam logic [2:0] REG_INV_X      = 3'd4;
  localparam logic [2:0] REG_INV_Z      = 3'd5;
  localparam logic [2:0] REG_GAIN       = 3'd6;

  localparam logic [DIM_W-1:0] RST_GRID_WIDTH = DIM_W'(512);
  localparam logic [DIM_W-1:0] RST_GRID_DEPTH = DIM_W'(512);
  localparam logic [VAL_W-1:0] RST_CELL       = VAL_W'(65536);
  localparam logic [VAL_W-1:0] RST_GAIN       = VAL_W'(6554);

  typedef struct packed {
    logic [DIM_W-1:0] grid_width;
    logic [DIM_W-1:0] grid_depth;
    logic [VAL_W-1:0] cell_size_x;
    logic [VAL_W-1:0] cell_size_z;
    logic [VAL_W-1:0] inv_cell_size_x;
    logic [VAL_W-1:0] inv_cell_size_z;
    logic [VAL_W-1:0] height_gain;
  } cfg_t;

  // One classified item
  typedef struct packed {
    op_t                                 op;
    logic                                in_cell;
    logic                                at_edge;
    logic                                flip;
    logic                                sel;
    logic                                xpar;
    logic                                zpar;
    logic [FRAC_BITS-1:0]                xp;
    logic [FRAC_BITS-1:0]                zp;
    logic [NUM_BANKS-1:0][BANK_AW-1:0]   addr;
    logic [NUM_BANKS-1:0]                wmask;
    logic [SAMPLE_W-1:0]                 wdata;
  } qent_t;

endpackage

`default_nettype wire

### design/hts_front.sv
// ----------------------------------------------------------------------------
// hts_front: item intake and classification
// Registers each item with its scaled coordinates, then sorts it into load,
// inside-cell, edge-cell or outside and works out the four bank addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire hts_pkg::cfg_t                   cfg,
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic [1:0]                      command,
  input  wire logic signed [hts_pkg::COORD_W-1:0] coord_x,
  input  wire logic signed [hts_pkg::COORD_W-1:0] coord_z,
  input  wire logic                            diagonal_flip,
  input  wire logic [hts_pkg::COL_W-1:0]       load_column,
  input  wire logic [hts_pkg::ROW_W-1:0]       load_row,
  input  wire logic [hts_pkg::SAMPLE_W-1:0]    load_value,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output hts_pkg::qent_t                       q_ent
);

  localparam int F = hts_pkg::FRAC_BITS;

  logic                                   f1_valid;
  logic [1:0]                             f1_cmd;
  logic signed [hts_pkg::COORD_W-1:0]     f1_cx, f1_cz;
  logic                                   f1_flip;
  logic [hts_pkg::COL_W-1:0]              f1_col;
  logic [hts_pkg::ROW_W-1:0]              f1_row;
  logic [hts_pkg::SAMPLE_W-1:0]           f1_val;
  logic signed [hts_pkg::PROD_W-1:0]      f1_px, f1_pz;

  logic                                   unused_cmd, f1_done;
  logic                                   is_height;
  logic                                   negx, negz, outside, at_edge;
  logic [hts_pkg::POS_W-1:0]              posx, posz;
  logic [F-1:0]                           xp, zp;
  logic [hts_pkg::DIM_W-1:0]              effw, effd;
  logic [hts_pkg::COL_W-1:0]              xi;
  logic [hts_pkg::ROW_W-1:0]              zi;
  logic [hts_pkg::COL_W:0]                x1;
  logic [hts_pkg::ROW_W:0]                z1;
  logic [hts_pkg::ROW_W-1:0]              rflip;
  logic                                   load_ok;
  logic [1:0]                             wbank;

  assign unused_cmd = (f1_cmd != hts_pkg::OP_LOAD) && (f1_cmd != hts_pkg::OP_HEIGHT)
                   && (f1_cmd != hts_pkg::OP_NORMAL);
  assign f1_done    = f1_valid && (unused_cmd || !q_full);
  assign q_push     = f1_valid && !unused_cmd && !q_full;
  assign item_stall = f1_valid && !f1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (!item_stall) begin
      f1_valid <= item_valid;
    end
    if (item_valid && !item_stall) begin
      f1_cmd  <= command;
      f1_cx   <= coord_x;
      f1_cz   <= coord_z;
      f1_flip <= diagonal_flip;
      f1_col  <= load_column;
      f1_row  <= load_row;
      f1_val  <= load_value;
      f1_px   <= coord_x * $signed({1'b0, cfg.inv_cell_size_x});
      f1_pz   <= coord_z * $signed({1'b0, cfg.inv_cell_size_z});
    end
  end

  always_comb begin
    effw = (cfg.grid_width > hts_pkg::DIM_W'(hts_pkg::MAX_WIDTH))
         ? hts_pkg::DIM_W'(hts_pkg::MAX_WIDTH) : cfg.grid_width;
    effd = (cfg.grid_depth > hts_pkg::DIM_W'(hts_pkg::MAX_DEPTH))
         ? hts_pkg::DIM_W'(hts_pkg::MAX_DEPTH) : cfg.grid_depth;

    is_height = (f1_cmd == hts_pkg::OP_HEIGHT);
    if (is_height) begin
      negx = f1_px[hts_pkg::PROD_W-1];
      negz = f1_pz[hts_pkg::PROD_W-1];
      posx = f1_px[hts_pkg::PROD_W-2:2*F];
      posz = f1_pz[hts_pkg::PROD_W-2:2*F];
      xp   = f1_px[2*F-1:F];
      zp   = f1_pz[2*F-1:F];
    end else begin
      negx = f1_cx[hts_pkg::COORD_W-1];
      negz = f1_cz[hts_pkg::COORD_W-1];
      posx = hts_pkg::POS_W'(f1_cx[hts_pkg::COORD_W-1:F]);
      posz = hts_pkg::POS_W'(f1_cz[hts_pkg::COORD_W-1:F]);
      xp   = f1_cx[F-1:0];
      zp   = f1_cz[F-1:0];
    end

    outside = negx || negz || (posx >= hts_pkg::POS_W'(effw))
           || (posz >= hts_pkg::POS_W'(effd));
    at_edge = !outside
           && ((({1'b0, posx} + 1'b1) >= (hts_pkg::POS_W + 1)'(effw))
            || (({1'b0, posz} + 1'b1) >= (hts_pkg::POS_W + 1)'(effd)));

    xi = posx[hts_pkg::COL_W-1:0];
    zi = posz[hts_pkg::ROW_W-1:0];
    x1 = {1'b0, xi} + 1'b1;
    z1 = {1'b0, zi} + 1'b1;

    // Load: flip rows so the first loaded row lands on the top row
    load_ok = ((hts_pkg::DIM_W)'(f1_col) < effw) && ((hts_pkg::DIM_W)'(f1_row) < effd);
    rflip   = hts_pkg::ROW_W'(effd - hts_pkg::DIM_W'(1) - hts_pkg::DIM_W'(f1_row));
    wbank   = {rflip[0], f1_col[0]};

    q_ent         = '0;
    q_ent.op      = hts_pkg::op_t'(f1_cmd);
    q_ent.in_cell = !outside && !at_edge;
    q_ent.at_edge = at_edge;
    q_ent.flip    = f1_flip;
    q_ent.sel     = f1_flip ? (zp >= xp)
                  : (({1'b0, xp} + {1'b0, zp}) >= (F + 1)'(hts_pkg::ONE_FX));
    q_ent.xpar    = xi[0];
    q_ent.zpar    = zi[0];
    q_ent.xp      = xp;
    q_ent.zp      = zp;
    q_ent.wdata   = f1_val;
    if (f1_cmd == hts_pkg::OP_LOAD) begin
      for (int b = 0; b < hts_pkg::NUM_BANKS; b++) begin
        q_ent.addr[b] = {rflip[hts_pkg::ROW_W-1:1], f1_col[hts_pkg::COL_W-1:1]};
      end
      q_ent.wmask = load_ok ? (hts_pkg::NUM_BANKS'(1) << wbank) : '0;
    end else begin
      // Bank {row parity, column parity} holds exactly one of the four corners
      for (int b = 0; b < hts_pkg::NUM_BANKS; b++) begin
        q_ent.addr[b] = {
          ((b / 2) == int'(zi[0])) ? zi[hts_pkg::ROW_W-1:1] : z1[hts_pkg::ROW_W-1:1],
          ((b % 2) == int'(xi[0])) ? xi[hts_pkg::COL_W-1:1] : x1[hts_pkg::COL_W-1:1]
        };
      end
    end
  end

endmodule

`default_nettype wire

### design/hts_queue.sv
// ----------------------------------------------------------------------------
// hts_queue: short item queue
// Holds classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire hts_pkg::qent_t push_ent,
  output logic                full,
  input  wire logic           pop,
  output hts_pkg::qent_t      head,
  output logic                empty
);

  localparam int PTR_W = $clog2(hts_pkg::QUEUE_DEPTH);

  hts_pkg::qent_t   slots [hts_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W + 1)'(hts_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_ent;
    end
  end

endmodule

`default_nettype wire

### design/hts_back.sv
// ----------------------------------------------------------------------------
// hts_back: grid storage and answer datapath
// Four parity banks give all corners of a cell in one read; then triangle
// interpolation, gain scaling and the normal cross product, five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire hts_pkg::cfg_t                      cfg,
  input  wire hts_pkg::qent_t                     head,
  input  wire logic                               q_empty,
  output logic                                    q_pop,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic                                    answer_kind,
  output logic                                    inside_grid,
  output logic signed [hts_pkg::OUT_W-1:0]        height_out,
  output logic signed [hts_pkg::OUT_W-1:0]        normal_x,
  output logic signed [hts_pkg::OUT_W-1:0]        normal_y,
  output logic signed [hts_pkg::OUT_W-1:0]        normal_z
);

  localparam int F    = hts_pkg::FRAC_BITS;
  localparam int SW   = hts_pkg::SAMPLE_W;
  localparam int CW   = SW + 2;
  localparam int TB_W = CW + F + 2;
  localparam int H_W  = TB_W - 1;
  localparam int BL_W = TB_W + F + 2;
  localparam int HG_W = H_W + hts_pkg::VAL_W + 1;
  localparam int D_W  = SW + 1;
  localparam int NX_W = hts_pkg::VAL_W + 1 + D_W;
  localparam int NY_W = 2 * hts_pkg::VAL_W;

  typedef struct packed {
    hts_pkg::op_t op;
    logic         in_cell;
    logic         at_edge;
  } meta_t;

  logic adv;

  // B0: bank read
  logic                 b0_valid;
  meta_t                b0_meta;
  logic                 b0_flip, b0_sel, b0_xpar, b0_zpar;
  logic [F-1:0]         b0_xp, b0_zp;
  logic [SW-1:0]        rd [hts_pkg::NUM_BANKS];

  // B1: row blends
  logic                 b1_valid;
  meta_t                b1_meta;
  logic [F-1:0]         b1_zp;
  logic signed [TB_W-1:0] b1_top, b1_bot;
  logic [SW-1:0]        b1_smp;
  logic signed [D_W-1:0] b1_dnx, b1_dnz;

  // B2: column blend
  logic                 b2_valid;
  meta_t                b2_meta;
  logic signed [H_W-1:0] b2_h;
  logic [SW-1:0]        b2_smp;
  logic signed [D_W-1:0] b2_dnx, b2_dnz;

  // B3: products
  logic                 b3_valid;
  meta_t                b3_meta;
  logic signed [HG_W-1:0] b3_hg;
  logic signed [NX_W-1:0] b3_nx, b3_nz;
  logic [NY_W-1:0]      b3_ny;

  // Combinational
  logic [SW-1:0]        rbl, rbr, rtl, rtr, y1, y2, y3;
  logic signed [CW-1:0] cbl, cbr, ctl, ctr;
  logic signed [F+1:0]  wx, xs, wz, zs;
  logic signed [TB_W-1:0] top_next, bot_next;
  logic signed [BL_W-1:0] blend;
  logic signed [H_W-1:0]  hop;
  logic signed [hts_pkg::VAL_W:0] gain_s, csx_s, csz_s;

  assign adv   = !(result_valid && result_stall);
  assign q_pop = adv && !q_empty;

  for (genvar b = 0; b < hts_pkg::NUM_BANKS; b++) begin : g_bank
    logic [SW-1:0] mem [hts_pkg::BANK_DEPTH];
    logic [SW-1:0] rd_q;
    always_ff @(posedge clk) begin
      if (q_pop && head.wmask[b]) begin
        mem[head.addr[b]] <= head.wdata;
      end
      if (adv) begin
        rd_q <= mem[head.addr[b]];
      end
    end
    assign rd[b] = rd_q;
  end

  always_comb begin
    rbl = rd[{b0_zpar, b0_xpar}];
    rbr = rd[{b0_zpar, !b0_xpar}];
    rtl = rd[{!b0_zpar, b0_xpar}];
    rtr = rd[{!b0_zpar, !b0_xpar}];

    cbl = $signed(CW'(rbl));
    cbr = $signed(CW'(rbr));
    ctl = $signed(CW'(rtl));
    ctr = $signed(CW'(rtr));
    // Replace the corner off the chosen triangle by its planar extension
    if (b0_flip) begin
      if (b0_sel) begin
        cbr = cbl + ctr - ctl;
      end else begin
        ctl = ctr + cbl - cbr;
      end
    end else begin
      if (!b0_sel) begin
        ctr = ctl + cbr - cbl;
      end else begin
        cbl = ctl + cbr - ctr;
      end
    end
    xs = $signed({2'b00, b0_xp});
    wx = $signed((F + 2)'(hts_pkg::ONE_FX)) - xs;
    top_next = ctl * wx + ctr * xs;
    bot_next = cbl * wx + cbr * xs;

    case ({b0_flip, b0_sel})
      2'b11:   begin y1 = rtl; y2 = rbl; y3 = rtr; end
      2'b10:   begin y1 = rbr; y2 = rbl; y3 = rtr; end
      2'b00:   begin y1 = rbl; y2 = rtl; y3 = rbr; end
      default: begin y1 = rtr; y2 = rbr; y3 = rtl; end
    endcase

    zs    = $signed({2'b00, b1_zp});
    wz    = $signed((F + 2)'(hts_pkg::ONE_FX)) - zs;
    blend = b1_bot * wz + b1_top * zs;

    gain_s = $signed({1'b0, cfg.height_gain});
    csx_s  = $signed({1'b0, cfg.cell_size_x});
    csz_s  = $signed({1'b0, cfg.cell_size_z});
    if (b2_meta.at_edge) begin
      hop = $signed(H_W'({b2_smp, F'(0)}));
    end else if (b2_meta.in_cell) begin
      hop = b2_h;
    end else begin
      hop = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_valid     <= 1'b0;
      b1_valid     <= 1'b0;
      b2_valid     <= 1'b0;
      b3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      b0_valid     <= q_pop && (head.op != hts_pkg::OP_LOAD);
      b1_valid     <= b0_valid;
      b2_valid     <= b1_valid;
      b3_valid     <= b2_valid;
      result_valid <= b3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b0_meta <= '{op: head.op, in_cell: head.in_cell, at_edge: head.at_edge};
      b0_flip <= head.flip;
      b0_sel  <= head.sel;
      b0_xpar <= head.xpar;
      b0_zpar <= head.zpar;
      b0_xp   <= head.xp;
      b0_zp   <= head.zp;

      b1_meta <= b0_meta;
      b1_zp   <= b0_zp;
      b1_top  <= top_next;
      b1_bot  <= bot_next;
      b1_smp  <= rbl;
      b1_dnx  <= $signed({1'b0, y1}) - $signed({1'b0, y2});
      b1_dnz  <= $signed({1'b0, y1}) - $signed({1'b0, y3});

      b2_meta <= b1_meta;
      b2_h    <= $signed(blend[F+H_W-1:F]);
      b2_smp  <= b1_smp;
      b2_dnx  <= b1_dnx;
      b2_dnz  <= b1_dnz;

      b3_meta <= b2_meta;
      b3_hg   <= hop * gain_s;
      b3_nx   <= csz_s * b2_dnx;
      b3_nz   <= csx_s * b2_dnz;
      b3_ny   <= cfg.cell_size_x * cfg.cell_size_z;

      answer_kind <= (b3_meta.op == hts_pkg::OP_NORMAL);
      inside_grid <= b3_meta.in_cell;
      if (b3_meta.op == hts_pkg::OP_NORMAL) begin
        height_out <= '0;
        if (b3_meta.in_cell) begin
          normal_x <= hts_pkg::OUT_W'(b3_nx);
          normal_y <= $signed(hts_pkg::OUT_W'(b3_ny[NY_W-1:F]));
          normal_z <= hts_pkg::OUT_W'(b3_nz);
        end else begin
          normal_x <= '0;
          normal_y <= $signed(hts_pkg::OUT_W'(hts_pkg::ONE_FX));
          normal_z <= '0;
        end
      end else begin
        height_out <= hts_pkg::OUT_W'($signed(b3_hg[HG_W-1:F]));
        normal_x   <= '0;
        normal_y   <= '0;
        normal_z   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### design/heightmap_triangle_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler: height grid with triangle interpolation
// Loads 8-bit grid samples, answers height queries (scaled, interpolated,
// gain applied) and normal queries (cross product of triangle edges).
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_stall      command, coord_x, coord_z,
//                                                    diagonal_flip, load_column,
//                                                    load_row, load_value
//  result    out        result_valid / result_stall  answer_kind, inside_grid,
//                                                    height_out, normal_x/y/z
//  config    in         APB psel/penable/pwrite      7 registers at 4*index
//
//  One item per cycle sustained while result_stall is low; the four parity banks
//  each serve one corner read per cycle, which sets that rate. A query's result
//  passes through the front register, 1 queue slot and 5 back stages before
//  it is presented.
//  Loads and command 3 give no result. Reset clears control and registers;
//  the grid samples are undefined until loaded, and no clearing pass runs.
//  A stalled result freezes the back; the 4-entry queue keeps the front taking
//  items until it fills, then item_stall rises.
//
`default_nettype none

module heightmap_triangle_sampler (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Item channel
  input  wire logic                                item_valid,
  output logic                                     item_stall,
  input  wire logic [1:0]                          command,
  input  wire logic signed [hts_pkg::COORD_W-1:0]  coord_x,
  input  wire logic signed [hts_pkg::COORD_W-1:0]  coord_z,
  input  wire logic                                diagonal_flip,
  input  wire logic [hts_pkg::COL_W-1:0]           load_column,
  input  wire logic [hts_pkg::ROW_W-1:0]           load_row,
  input  wire logic [hts_pkg::SAMPLE_W-1:0]        load_value,
  // Result channel
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic                                     answer_kind,
  output logic                                     inside_grid,
  output logic signed [hts_pkg::OUT_W-1:0]         height_out,
  output logic signed [hts_pkg::OUT_W-1:0]         normal_x,
  output logic signed [hts_pkg::OUT_W-1:0]         normal_y,
  output logic signed [hts_pkg::OUT_W-1:0]         normal_z,
  // Configuration
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [hts_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [hts_pkg::PDATA_W-1:0]         pwdata,
  output logic [hts_pkg::PDATA_W-1:0]              prdata,
  output logic                                     pready
);

  hts_pkg::cfg_t  cfg;
  hts_pkg::qent_t push_ent, head;
  logic           q_push, q_pop, q_full, q_empty;
  logic           cfg_wr;
  logic [2:0]     reg_idx;

  // Register file: to be written only while idle, which the block does not enforce, so every stage may read it
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[hts_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width      <= hts_pkg::RST_GRID_WIDTH;
      cfg.grid_depth      <= hts_pkg::RST_GRID_DEPTH;
      cfg.cell_size_x     <= hts_pkg::RST_CELL;
      cfg.cell_size_z     <= hts_pkg::RST_CELL;
      cfg.inv_cell_size_x <= hts_pkg::RST_CELL;
      cfg.inv_cell_size_z <= hts_pkg::RST_CELL;
      cfg.height_gain     <= hts_pkg::RST_GAIN;
    end else if (cfg_wr) begin
      case (reg_idx)
        hts_pkg::REG_GRID_WIDTH: cfg.grid_width      <= pwdata[hts_pkg::DIM_W-1:0];
        hts_pkg::REG_GRID_DEPTH: cfg.grid_depth      <= pwdata[hts_pkg::DIM_W-1:0];
        hts_pkg::REG_CELL_X:     cfg.cell_size_x     <= pwdata[hts_pkg::VAL_W-1:0];
        hts_pkg::REG_CELL_Z:     cfg.cell_size_z     <= pwdata[hts_pkg::VAL_W-1:0];
        hts_pkg::REG_INV_X:      cfg.inv_cell_size_x <= pwdata[hts_pkg::VAL_W-1:0];
        hts_pkg::REG_INV_Z:      cfg.inv_cell_size_z <= pwdata[hts_pkg::VAL_W-1:0];
        hts_pkg::REG_GAIN:       cfg.height_gain     <= pwdata[hts_pkg::VAL_W-1:0];
        default:                 ; // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hts_pkg::REG_GRID_WIDTH: prdata = hts_pkg::PDATA_W'(cfg.grid_width);
      hts_pkg::REG_GRID_DEPTH: prdata = hts_pkg::PDATA_W'(cfg.grid_depth);
      hts_pkg::REG_CELL_X:     prdata = hts_pkg::PDATA_W'(cfg.cell_size_x);
      hts_pkg::REG_CELL_Z:     prdata = hts_pkg::PDATA_W'(cfg.cell_size_z);
      hts_pkg::REG_INV_X:      prdata = hts_pkg::PDATA_W'(cfg.inv_cell_size_x);
      hts_pkg::REG_INV_Z:      prdata = hts_pkg::PDATA_W'(cfg.inv_cell_size_z);
      hts_pkg::REG_GAIN:       prdata = hts_pkg::PDATA_W'(cfg.height_gain);
      default:                 prdata = '0;
    endcase
  end

  // Front: take items, scale coordinates, classify and address the banks
  hts_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .command       (command),
    .coord_x       (coord_x),
    .coord_z       (coord_z),
    .diagonal_flip (diagonal_flip),
    .load_column   (load_column),
    .load_row      (load_row),
    .load_value    (load_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_ent         (push_ent)
  );

  // Queue: lets the front keep taking items while a result is held
  hts_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (push_ent),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  // Back: write or read the banks, interpolate, scale, build normals
  hts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .answer_kind  (answer_kind),
    .inside_grid  (inside_grid),
    .height_out   (height_out),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z)
  );

endmodule

`default_nettype wire
